>>> hdl/hex_reply_frame_checker_assert.svh
// Assertion macros shared by the frame checker RTL.
`ifndef HEX_REPLY_FRAME_CHECKER_ASSERT_SVH
`define HEX_REPLY_FRAME_CHECKER_ASSERT_SVH

// Checked property, disabled while reset is asserted.
`define HRFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked property that also holds during reset.
`define HRFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/hrfc_pkg.sv
`timescale 1ns / 1ps
package hrfc_pkg;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_TICK  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_VALUE_OK  = 3'd0,
    ST_ACK_OK    = 3'd1,
    ST_DEV_ERROR = 3'd2,
    ST_ERR_BADCRC = 3'd3,
    ST_BAD_CRC   = 3'd4,
    ST_MALFORMED = 3'd5,
    ST_UNEXPECTED = 3'd6,
    ST_TIMEOUT   = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_ADDR    = 4'd1,
    PH_SEQ     = 4'd2,
    PH_PAYLOAD = 4'd3,
    PH_ERRCODE = 4'd4,
    PH_VALUE   = 4'd5,
    PH_CRC     = 4'd6,
    PH_CR      = 4'd7,
    PH_ERRCRC  = 4'd8,
    PH_ERRCR   = 4'd9
  } phase_e;

  localparam logic [7:0]  CH_START = 8'h21;  // '!'
  localparam logic [7:0]  CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0]  CH_CR    = 8'h0D;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  localparam logic [3:0] ADDR_DIGITS  = 4'd2;
  localparam logic [3:0] SEQ_DIGITS   = 4'd4;
  localparam logic [3:0] ECODE_DIGITS = 4'd2;
  localparam logic [3:0] VALUE_DIGITS = 4'd8;
  localparam logic [3:0] CRC_DIGITS   = 4'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  rx_byte;
    logic [7:0]  req_address;
    logic [15:0] req_sequence;
    logic        req_is_ack;
    logic [15:0] req_checksum;
  } in_item_t;

  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [31:0] reply_value;
    logic [7:0]  device_error_code;
    logic        id_mismatch;
  } result_t;

  // CRC-16/XMODEM, one byte, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Case-insensitive hex digit: {is_digit, value}.
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

>>> hdl/hrfc_in_if.sv
`timescale 1ns / 1ps
interface hrfc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  rx_byte;
  logic [7:0]  req_address;
  logic [15:0] req_sequence;
  logic        req_is_ack;
  logic [15:0] req_checksum;

  modport source (
    output valid, mode, rx_byte, req_address, req_sequence, req_is_ack, req_checksum,
    input  ready
  );
  modport sink (
    input  valid, mode, rx_byte, req_address, req_sequence, req_is_ack, req_checksum,
    output ready
  );
endinterface

>>> hdl/hrfc_out_if.sv
`timescale 1ns / 1ps
interface hrfc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] reply_value;
  logic [7:0]  device_error_code;
  logic        id_mismatch;

  modport source (
    output valid, status, reply_value, device_error_code, id_mismatch,
    input  ready
  );
  modport sink (
    input  valid, status, reply_value, device_error_code, id_mismatch,
    output ready
  );
endinterface

>>> hdl/hrfc_frame_core.sv
`timescale 1ns / 1ps
`include "hex_reply_frame_checker_assert.svh"
module hrfc_frame_core import hrfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  in_item_t    item_i,
  input  logic [15:0] timeout_i,
  output result_t     result_o
);

  logic        busy_q, busy_d;
  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] fcrc_q, fcrc_d;
  logic [7:0]  exp_addr_q, exp_addr_d;
  logic [15:0] exp_seq_q, exp_seq_d;
  logic        exp_ack_q, exp_ack_d;
  logic [15:0] req_crc_q, req_crc_d;
  logic        mism_q, mism_d;
  logic [7:0]  ecode_q, ecode_d;
  logic [31:0] value_q, value_d;
  logic [15:0] wait_q, wait_d;

  logic [7:0]  b;
  logic [4:0]  hex;
  logic [15:0] crc_upd;
  logic [31:0] acc_new;
  logic [3:0]  cnt_inc;
  logic [15:0] wait_inc;
  phase_e      phase_eff;
  phase_e      nxt;
  logic        digit_ph, crc_on, fits, do_clear;
  logic [3:0]  need;
  logic [15:0] crc_ref;
  result_t     res;

  assign b        = item_i.rx_byte;
  assign hex      = hex_decode(b);
  assign crc_upd  = crc16_byte(crc_q, b);
  assign acc_new  = {acc_q[27:0], hex[3:0]};
  assign cnt_inc  = cnt_q + 4'd1;
  assign wait_inc = wait_q + 16'd1;
  assign crc_ref  = exp_ack_q ? req_crc_q : crc_q;

  // A payload byte other than '+' is handled as the first byte of the next field.
  always_comb begin
    phase_eff = phase_q;
    if (phase_q == PH_PAYLOAD && b != CH_PLUS) begin
      phase_eff = exp_ack_q ? PH_CRC : PH_VALUE;
    end
  end

  always_comb begin
    digit_ph = 1'b1;
    crc_on   = 1'b1;
    need     = CRC_DIGITS;
    nxt      = PH_START;
    unique case (phase_eff)
      PH_ADDR:    begin need = ADDR_DIGITS;  nxt = PH_SEQ;     end
      PH_SEQ:     begin need = SEQ_DIGITS;   nxt = PH_PAYLOAD; end
      PH_ERRCODE: begin need = ECODE_DIGITS; nxt = PH_ERRCRC;  end
      PH_VALUE:   begin need = VALUE_DIGITS; nxt = PH_CRC;     end
      PH_CRC:     begin crc_on = 1'b0;       nxt = PH_CR;      end
      PH_ERRCRC:  begin crc_on = 1'b0;       nxt = PH_ERRCR;   end
      default:    digit_ph = 1'b0;
    endcase
  end

  always_comb begin
    busy_d     = busy_q;
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    acc_d      = acc_q;
    crc_d      = crc_q;
    fcrc_d     = fcrc_q;
    exp_addr_d = exp_addr_q;
    exp_seq_d  = exp_seq_q;
    exp_ack_d  = exp_ack_q;
    req_crc_d  = req_crc_q;
    mism_d     = mism_q;
    ecode_d    = ecode_q;
    value_d    = value_q;
    wait_d     = wait_q;
    do_clear   = 1'b0;
    fits       = 1'b1;
    res        = '0;

    if (step_i) begin
      unique case (item_i.mode)
        MODE_START: begin
          busy_d     = 1'b1;
          exp_addr_d = item_i.req_address;
          exp_seq_d  = item_i.req_sequence;
          exp_ack_d  = item_i.req_is_ack;
          req_crc_d  = item_i.req_checksum;
          do_clear   = 1'b1;
        end
        MODE_BYTE: begin
          if (!busy_q) begin
            res.valid  = 1'b1;
            res.status = ST_UNEXPECTED;
          end else if (digit_ph) begin
            fits = hex[4];
            if (hex[4]) begin
              // Leave the payload phase once its first byte is taken as a digit.
              phase_d = phase_eff;
              if (crc_on) begin
                crc_d = crc_upd;
              end
              acc_d = acc_new;
              cnt_d = cnt_inc;
              if (cnt_inc == need) begin
                phase_d = nxt;
                cnt_d   = 4'd0;
                acc_d   = 32'd0;
                unique case (phase_eff)
                  PH_ADDR: begin
                    if (acc_new[7:0] != exp_addr_q) mism_d = 1'b1;
                  end
                  PH_SEQ: begin
                    if (acc_new[15:0] != exp_seq_q) mism_d = 1'b1;
                  end
                  PH_ERRCODE: ecode_d = acc_new[7:0];
                  PH_VALUE:   value_d = acc_new;
                  default:    fcrc_d  = acc_new[15:0];
                endcase
              end
            end
          end else begin
            unique case (phase_eff)
              PH_START: begin
                fits = (b == CH_START);
                if (fits) begin
                  crc_d   = crc_upd;
                  phase_d = PH_ADDR;
                end
              end
              PH_PAYLOAD: begin
                // Only '+' reaches here.
                crc_d   = crc_upd;
                phase_d = PH_ERRCODE;
              end
              PH_CR: begin
                fits = (b == CH_CR);
                if (fits) begin
                  res.valid       = 1'b1;
                  res.id_mismatch = mism_q;
                  if (fcrc_q != crc_ref) begin
                    res.status = ST_BAD_CRC;
                  end else if (exp_ack_q) begin
                    res.status = ST_ACK_OK;
                  end else begin
                    res.status      = ST_VALUE_OK;
                    res.reply_value = value_q;
                  end
                end
              end
              PH_ERRCR: begin
                fits = (b == CH_CR);
                if (fits) begin
                  res.valid             = 1'b1;
                  res.id_mismatch       = mism_q;
                  res.device_error_code = ecode_q;
                  res.status = (fcrc_q == crc_q) ? ST_DEV_ERROR : ST_ERR_BADCRC;
                end
              end
              default: fits = 1'b0;
            endcase
          end
          if (busy_q && !fits) begin
            res.valid       = 1'b1;
            res.status      = ST_MALFORMED;
            res.id_mismatch = mism_q;
          end
          if (busy_q && res.valid) begin
            busy_d   = 1'b0;
            do_clear = 1'b1;
          end
        end
        MODE_TICK: begin
          if (busy_q) begin
            wait_d = wait_inc;
            if (wait_inc >= timeout_i) begin
              res.valid  = 1'b1;
              res.status = ST_TIMEOUT;
              busy_d     = 1'b0;
              do_clear   = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (do_clear) begin
      phase_d = PH_START;
      cnt_d   = 4'd0;
      acc_d   = 32'd0;
      crc_d   = 16'd0;
      fcrc_d  = 16'd0;
      mism_d  = 1'b0;
      ecode_d = 8'd0;
      value_d = 32'd0;
      wait_d  = 16'd0;
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      phase_q    <= PH_START;
      cnt_q      <= 4'd0;
      acc_q      <= 32'd0;
      crc_q      <= 16'd0;
      fcrc_q     <= 16'd0;
      exp_addr_q <= 8'd0;
      exp_seq_q  <= 16'd0;
      exp_ack_q  <= 1'b0;
      req_crc_q  <= 16'd0;
      mism_q     <= 1'b0;
      ecode_q    <= 8'd0;
      value_q    <= 32'd0;
      wait_q     <= 16'd0;
    end else begin
      busy_q     <= busy_d;
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      acc_q      <= acc_d;
      crc_q      <= crc_d;
      fcrc_q     <= fcrc_d;
      exp_addr_q <= exp_addr_d;
      exp_seq_q  <= exp_seq_d;
      exp_ack_q  <= exp_ack_d;
      req_crc_q  <= req_crc_d;
      mism_q     <= mism_d;
      ecode_q    <= ecode_d;
      value_q    <= value_d;
      wait_q     <= wait_d;
    end
  end

  `HRFC_ASSERT(a_result_needs_step, result_o.valid |-> step_i, "result without a step")
  `HRFC_ASSERT(a_idle_after_result, result_o.valid |=> !busy_q, "still busy after result")
  `HRFC_ASSERT_ALWAYS(a_idle_parser_clear,
    !busy_q |-> (phase_q == PH_START && cnt_q == 4'd0 && wait_q == 16'd0),
    "idle parser not cleared")

endmodule

>>> hdl/hex_reply_frame_checker.sv
`timescale 1ns / 1ps
`include "hex_reply_frame_checker_assert.svh"
// Reply frame checker for one pending request. A start request arms the
// expected address, sequence, reply kind and request CRC; byte requests are
// then parsed as an ASCII hex frame ('!', address, sequence, payload, CRC,
// CR) with a CRC-16/XMODEM over '!' through the payload, and tick requests
// count toward the timeout set by the timeout register (write it only while
// idle). One request is taken every clock cycle while no stalled sink holds
// the result register: the whole step for a request, including the
// 8-bit-parallel CRC update, is one pass of logic between the input register
// and the result register. While the result register is held by a stalled
// sink, the input register holds its request and input ready stays low until
// the result is taken.
module hex_reply_frame_checker import hrfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  hrfc_in_if.sink     in_i,
  hrfc_out_if.source  out_o
);

  logic [15:0] timeout_q;
  in_item_t    in_q;
  logic        in_valid_q, in_valid_d;
  result_t     out_q;
  logic        out_valid_q, out_valid_d;
  logic        accept, can_step;
  result_t     res;

  // Timeout register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // Advance the held request only when the result register is free or drains now.
  assign can_step   = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || can_step;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (can_step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Capture the request payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.mode         <= in_i.mode;
      in_q.rx_byte      <= in_i.rx_byte;
      in_q.req_address  <= in_i.req_address;
      in_q.req_sequence <= in_i.req_sequence;
      in_q.req_is_ack   <= in_i.req_is_ack;
      in_q.req_checksum <= in_i.req_checksum;
    end
  end

  hrfc_frame_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (can_step),
    .item_i    (in_q),
    .timeout_i (timeout_q),
    .result_o  (res)
  );

  // Result register: load on a new result, drop once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (can_step && res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_step && res.valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.status            = out_q.status;
  assign out_o.reply_value       = out_q.reply_value;
  assign out_o.device_error_code = out_q.device_error_code;
  assign out_o.id_mismatch       = out_q.id_mismatch;

  `HRFC_ASSERT(a_accept_fills_input, accept |=> in_valid_q, "accepted request lost")
  `HRFC_ASSERT(a_blocked_request_held, (in_valid_q && !can_step) |=> in_valid_q,
    "blocked request dropped")
  `HRFC_ASSERT(a_stalled_result_held, (out_valid_q && !out_o.ready) |=> out_valid_q,
    "stalled result dropped")

endmodule
